[rtl/dual_view_aspect_fit_layout_core_defines.svh]
// Assertion macros for the dual view aspect fit layout core.
`ifndef DUAL_VIEW_ASPECT_FIT_LAYOUT_CORE_DEFINES_SVH
`define DUAL_VIEW_ASPECT_FIT_LAYOUT_CORE_DEFINES_SVH
`ifndef SYNTH
`define DVAFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DVAFL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define DVAFL_ASSERT(lbl, prop, msg)
`define DVAFL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/dvafl_pkg.sv]
// Shared widths, codes and reset values of the dual view aspect fit layout core.
package dvafl_pkg;
    localparam int DIM_W   = 16;
    localparam int SUM_W   = 17;
    localparam int PROD_W  = 32;
    localparam int UV_FRAC = 16;
    localparam int UV_W    = 17;
    localparam int NUM_W   = 33;
    localparam int DEN_W   = 17;
    localparam int QUO_W   = 17;
    localparam int DIV_LAT = QUO_W;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [DIM_W-1:0] TEXTURE_LIMIT_RST = 16'd16384;
    localparam logic REG_TEXTURE_LIMIT = 1'b0;

    typedef logic [DIM_W-1:0] dim_t;

    typedef enum logic [1:0] {
        MODE_SIDE    = 2'd0,
        MODE_STACK   = 2'd1,
        MODE_SCALED  = 2'd2,
        MODE_INVALID = 2'd3
    } mode_t;
endpackage

[rtl/dual_view_aspect_fit_layout_core.sv]
// Top level of the dual view aspect fit layout core.
// Each input word (two source sizes) yields two result words, left view then
// right view, on the one result port, so that result port sets the rate at which
// input words are taken; the whole pipeline stalls while it is blocked. The
// datapath is a 59 stage pipeline holding three 17 stage pipelined restoring
// dividers in series (layout scale, aspect fit, texture coordinates), followed
// by the output buffer. texture_limit is sampled when the input word is
// taken; write it only while the core is idle.
`include "dual_view_aspect_fit_layout_core_defines.svh"
module dual_view_aspect_fit_layout_core
    import dvafl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [DIM_W-1:0]   left_w,
    input  logic [DIM_W-1:0]   left_h,
    input  logic [DIM_W-1:0]   right_w,
    input  logic [DIM_W-1:0]   right_h,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               is_right_last,
    output logic [DIM_W-1:0]   rect_x,
    output logic [DIM_W-1:0]   rect_y,
    output logic [DIM_W-1:0]   rect_w,
    output logic [DIM_W-1:0]   rect_h,
    output logic [UV_W-1:0]    u_lo,
    output logic [UV_W-1:0]    u_hi,
    output logic [UV_W-1:0]    v_lo,
    output logic [UV_W-1:0]    v_hi,
    output logic [DIM_W-1:0]   comp_w,
    output logic [DIM_W-1:0]   comp_h,
    output logic [1:0]         layout_mode
);
    localparam int ST_S2    = 2;
    localparam int SCL_OUT  = ST_S2 + DIV_LAT;
    localparam int ST_S3    = SCL_OUT + 1;
    localparam int ST_S5    = ST_S3 + 2;
    localparam int FIT_OUT  = ST_S5 + DIV_LAT;
    localparam int ST_S6    = FIT_OUT + 1;
    localparam int UV_OUT   = ST_S6 + DIV_LAT;
    localparam int ST_S7    = UV_OUT + 1;
    localparam int PIPE_LEN = ST_S7 + 1;

    typedef struct packed {
        dim_t lw;
        dim_t lh;
        dim_t rw;
        dim_t rh;
    } src_t;

    typedef struct packed {
        src_t             src;
        logic [SUM_W-1:0] hw;
        logic [SUM_W-1:0] vh;
        dim_t             hh;
        dim_t             vw;
        mode_t            mode;
    } scl_side_t;

    typedef struct packed {
        dim_t sw;
        dim_t sh;
        dim_t tx;
        dim_t ty;
        dim_t tw;
        dim_t th;
    } cell_t;

    typedef struct packed {
        dim_t  cw;
        dim_t  ch;
        mode_t mode;
    } common_t;

    typedef struct packed {
        cell_t slot;
        logic  wide;
        logic  zero;
    } fit_side_t;

    typedef struct packed {
        dim_t x;
        dim_t y;
        dim_t w;
        dim_t h;
    } box_t;

    typedef struct packed {
        dim_t            rect_x;
        dim_t            rect_y;
        dim_t            rect_w;
        dim_t            rect_h;
        logic [UV_W-1:0] u_lo;
        logic [UV_W-1:0] u_hi;
        logic [UV_W-1:0] v_lo;
        logic [UV_W-1:0] v_hi;
        dim_t            comp_w;
        dim_t            comp_h;
        mode_t           mode;
    } view_out_t;

    // configuration
    dim_t lim_reg;
    logic cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == REG_TEXTURE_LIMIT);
    assign prdata  = cfg_hit ? PDATA_W'(lim_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lim_reg <= TEXTURE_LIMIT_RST;
        else if (psel && penable && pwrite && pready && cfg_hit)
            lim_reg <= pwdata[DIM_W-1:0];
    end

    // pipeline control
    logic [PIPE_LEN-1:0] vld_reg;
    logic                en;
    logic                ob_load;
    logic                ob_vld_reg;
    logic                ob_phase_reg;

    assign ob_load    = vld_reg[PIPE_LEN-1] && (!ob_vld_reg || (ob_phase_reg && result_ready));
    assign en         = !vld_reg[PIPE_LEN-1] || ob_load;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LEN-2:0], item_valid};
    end

    // stage 0: layout choice
    src_t             s0_src_reg;
    dim_t             s0_lim_reg;
    logic [SUM_W-1:0] s0_hw;
    logic [SUM_W-1:0] s0_vh;
    dim_t             s0_hh;
    dim_t             s0_vw;
    logic [SUM_W-1:0] s0_m;
    mode_t            s0_mode;

    always_comb
    begin
        s0_hw = SUM_W'(s0_src_reg.lw) + SUM_W'(s0_src_reg.rw);
        s0_vh = SUM_W'(s0_src_reg.lh) + SUM_W'(s0_src_reg.rh);
        s0_hh = (s0_src_reg.lh > s0_src_reg.rh) ? s0_src_reg.lh : s0_src_reg.rh;
        s0_vw = (s0_src_reg.lw > s0_src_reg.rw) ? s0_src_reg.lw : s0_src_reg.rw;
        s0_m  = (s0_hw > SUM_W'(s0_hh)) ? s0_hw : SUM_W'(s0_hh);
        priority if (s0_src_reg.lw == '0 || s0_src_reg.lh == '0 ||
                     s0_src_reg.rw == '0 || s0_src_reg.rh == '0)
            s0_mode = MODE_INVALID;
        else if (s0_hw <= SUM_W'(s0_lim_reg) && s0_hh <= s0_lim_reg)
            s0_mode = MODE_SIDE;
        else if (s0_vw <= s0_lim_reg && s0_vh <= SUM_W'(s0_lim_reg))
            s0_mode = MODE_STACK;
        else
            s0_mode = MODE_SCALED;
    end

    // stage 1: scale products
    scl_side_t        s1_side_reg;
    logic [SUM_W-1:0] s1_m_reg;
    dim_t             s1_lim_reg;
    logic [PROD_W-1:0] s1_prod [4];

    always_comb
    begin
        s1_prod[0] = PROD_W'(s1_side_reg.src.lw) * PROD_W'(s1_lim_reg);
        s1_prod[1] = PROD_W'(s1_side_reg.src.lh) * PROD_W'(s1_lim_reg);
        s1_prod[2] = PROD_W'(s1_side_reg.src.rw) * PROD_W'(s1_lim_reg);
        s1_prod[3] = PROD_W'(s1_side_reg.src.rh) * PROD_W'(s1_lim_reg);
    end

    // stage 2 and scale dividers
    scl_side_t         s2_side_reg;
    logic [SUM_W-1:0]  s2_m_reg;
    logic [PROD_W-1:0] s2_prod_reg [4];
    logic [QUO_W-1:0]  scl_quo [4];
    scl_side_t         scl_side_reg [DIV_LAT];

    for (genvar i = 0; i < 4; i++) begin : g_scl
        dvafl_div u_div (
            .clk (clk),
            .en  (en),
            .num (NUM_W'(s2_prod_reg[i])),
            .den (DEN_W'(s2_m_reg)),
            .quo (scl_quo[i])
        );
    end

    // cells per layout
    scl_side_t sd;
    dim_t      slw;
    dim_t      slh;
    dim_t      srw;
    dim_t      srh;
    cell_t     c_cell [2];
    common_t   c_com;

    always_comb
    begin
        sd  = scl_side_reg[DIV_LAT-1];
        slw = scl_quo[0][DIM_W-1:0];
        slh = scl_quo[1][DIM_W-1:0];
        srw = scl_quo[2][DIM_W-1:0];
        srh = scl_quo[3][DIM_W-1:0];
        c_com.mode = sd.mode;
        unique case (sd.mode)
            MODE_SIDE:
            begin
                c_com.cw  = sd.hw[DIM_W-1:0];
                c_com.ch  = sd.hh;
                c_cell[0] = '{sw: sd.src.lw, sh: sd.src.lh, tx: '0, ty: '0,
                              tw: sd.src.lw, th: sd.hh};
                c_cell[1] = '{sw: sd.src.rw, sh: sd.src.rh, tx: sd.src.lw, ty: '0,
                              tw: sd.src.rw, th: sd.hh};
            end
            MODE_STACK:
            begin
                c_com.cw  = sd.vw;
                c_com.ch  = sd.vh[DIM_W-1:0];
                c_cell[0] = '{sw: sd.src.lw, sh: sd.src.lh, tx: '0, ty: '0,
                              tw: sd.vw, th: sd.src.lh};
                c_cell[1] = '{sw: sd.src.rw, sh: sd.src.rh, tx: '0, ty: sd.src.lh,
                              tw: sd.vw, th: sd.src.rh};
            end
            default:
            begin
                c_com.cw  = DIM_W'(slw + srw);
                c_com.ch  = (slh > srh) ? slh : srh;
                c_cell[0] = '{sw: slw, sh: slh, tx: '0, ty: '0, tw: slw, th: c_com.ch};
                c_cell[1] = '{sw: srw, sh: srh, tx: slw, ty: '0, tw: srw, th: c_com.ch};
            end
        endcase
    end

    // stage 3: cross products
    cell_t             s3_cell_reg [2];
    common_t           s3_com_reg;
    logic [PROD_W-1:0] s3_a [2];
    logic [PROD_W-1:0] s3_b [2];

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            s3_a[v] = PROD_W'(s3_cell_reg[v].sw) * PROD_W'(s3_cell_reg[v].th);
            s3_b[v] = PROD_W'(s3_cell_reg[v].tw) * PROD_W'(s3_cell_reg[v].sh);
        end
    end

    // stage 4: orientation
    cell_t             s4_cell_reg [2];
    common_t           s4_com_reg;
    logic [PROD_W-1:0] s4_a_reg [2];
    logic [PROD_W-1:0] s4_b_reg [2];
    fit_side_t         s4_fit [2];
    logic [PROD_W-1:0] s4_num [2];
    dim_t              s4_den [2];

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            s4_fit[v].slot = s4_cell_reg[v];
            s4_fit[v].zero = (s4_cell_reg[v].sw == '0) || (s4_cell_reg[v].sh == '0) ||
                             (s4_cell_reg[v].tw == '0) || (s4_cell_reg[v].th == '0);
            s4_fit[v].wide = s4_a_reg[v] > s4_b_reg[v];
            s4_num[v] = s4_fit[v].wide ? s4_b_reg[v] : s4_a_reg[v];
            s4_den[v] = s4_fit[v].wide ? s4_cell_reg[v].sw : s4_cell_reg[v].sh;
        end
    end

    // stage 5 and fit dividers
    fit_side_t         s5_fit_reg [2];
    common_t           s5_com_reg;
    logic [PROD_W-1:0] s5_num_reg [2];
    dim_t              s5_den_reg [2];
    logic [QUO_W-1:0]  fit_quo [2];
    fit_side_t         fit_side_reg [DIV_LAT][2];
    common_t           fit_com_reg [DIV_LAT];

    for (genvar v = 0; v < 2; v++) begin : g_fit
        dvafl_div u_div (
            .clk (clk),
            .en  (en),
            .num (NUM_W'(s5_num_reg[v])),
            .den (DEN_W'(s5_den_reg[v])),
            .quo (fit_quo[v])
        );
    end

    // fitted boxes
    fit_side_t fs [2];
    dim_t      fq [2];
    box_t      f_box [2];

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            fs[v] = fit_side_reg[DIV_LAT-1][v];
            fq[v] = fit_quo[v][DIM_W-1:0];
            priority if (fs[v].zero)
                f_box[v] = '{x: fs[v].slot.tx, y: fs[v].slot.ty,
                             w: fs[v].slot.tw, h: fs[v].slot.th};
            else if (fs[v].wide)
                f_box[v] = '{x: fs[v].slot.tx,
                             y: DIM_W'(fs[v].slot.ty + ((fs[v].slot.th - fq[v]) >> 1)),
                             w: fs[v].slot.tw, h: fq[v]};
            else
                f_box[v] = '{x: DIM_W'(fs[v].slot.tx + ((fs[v].slot.tw - fq[v]) >> 1)),
                             y: fs[v].slot.ty, w: fq[v], h: fs[v].slot.th};
        end
    end

    // stage 6 and texture coordinate dividers
    box_t             s6_box_reg [2];
    common_t          s6_com_reg;
    logic [SUM_W-1:0] s6_pos [2][4];
    logic [QUO_W-1:0] uv_quo [2][4];
    box_t             uv_box_reg [DIV_LAT][2];
    common_t          uv_com_reg [DIV_LAT];

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            s6_pos[v][0] = SUM_W'(s6_box_reg[v].x);
            s6_pos[v][1] = SUM_W'(s6_box_reg[v].x) + SUM_W'(s6_box_reg[v].w);
            s6_pos[v][2] = SUM_W'(s6_box_reg[v].y);
            s6_pos[v][3] = SUM_W'(s6_box_reg[v].y) + SUM_W'(s6_box_reg[v].h);
        end
    end

    for (genvar v = 0; v < 2; v++) begin : g_uv_view
        for (genvar j = 0; j < 4; j++) begin : g_uv
            dvafl_div u_div (
                .clk (clk),
                .en  (en),
                .num ({s6_pos[v][j], UV_FRAC'(0)}),
                .den (DEN_W'((j < 2) ? s6_com_reg.cw : s6_com_reg.ch)),
                .quo (uv_quo[v][j])
            );
        end
    end

    // result words
    common_t   uc;
    view_out_t u_out [2];

    always_comb
    begin
        uc = uv_com_reg[DIV_LAT-1];
        for (int v = 0; v < 2; v++)
        begin
            if (uc.mode == MODE_INVALID)
            begin
                u_out[v]      = '0;
                u_out[v].mode = MODE_INVALID;
            end
            else
            begin
                u_out[v].rect_x = uv_box_reg[DIV_LAT-1][v].x;
                u_out[v].rect_y = uv_box_reg[DIV_LAT-1][v].y;
                u_out[v].rect_w = uv_box_reg[DIV_LAT-1][v].w;
                u_out[v].rect_h = uv_box_reg[DIV_LAT-1][v].h;
                u_out[v].u_lo   = (uc.cw == '0) ? '0 : uv_quo[v][0];
                u_out[v].u_hi   = (uc.cw == '0) ? '0 : uv_quo[v][1];
                u_out[v].v_lo   = (uc.ch == '0) ? '0 : uv_quo[v][2];
                u_out[v].v_hi   = (uc.ch == '0) ? '0 : uv_quo[v][3];
                u_out[v].comp_w = uc.cw;
                u_out[v].comp_h = uc.ch;
                u_out[v].mode   = uc.mode;
            end
        end
    end

    view_out_t s7_out_reg [2];
    view_out_t ob_out_reg [2];
    view_out_t sel;

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s0_src_reg <= '{lw: left_w, lh: left_h, rw: right_w, rh: right_h};
            s0_lim_reg <= lim_reg;
        end
        if (en)
        begin
            s1_side_reg <= '{src: s0_src_reg, hw: s0_hw, vh: s0_vh, hh: s0_hh,
                             vw: s0_vw, mode: s0_mode};
            s1_m_reg    <= s0_m;
            s1_lim_reg  <= s0_lim_reg;
            s2_side_reg <= s1_side_reg;
            s2_m_reg    <= s1_m_reg;
            for (int i = 0; i < 4; i++)
                s2_prod_reg[i] <= s1_prod[i];
            scl_side_reg[0] <= s2_side_reg;
            fit_com_reg[0]  <= s5_com_reg;
            uv_com_reg[0]   <= s6_com_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                scl_side_reg[k] <= scl_side_reg[k-1];
                fit_com_reg[k]  <= fit_com_reg[k-1];
                uv_com_reg[k]   <= uv_com_reg[k-1];
            end
            s3_com_reg <= c_com;
            s4_com_reg <= s3_com_reg;
            s5_com_reg <= s4_com_reg;
            s6_com_reg <= fit_com_reg[DIV_LAT-1];
            for (int v = 0; v < 2; v++)
            begin
                s3_cell_reg[v]     <= c_cell[v];
                s4_cell_reg[v]     <= s3_cell_reg[v];
                s4_a_reg[v]        <= s3_a[v];
                s4_b_reg[v]        <= s3_b[v];
                s5_fit_reg[v]      <= s4_fit[v];
                s5_num_reg[v]      <= s4_num[v];
                s5_den_reg[v]      <= s4_den[v];
                fit_side_reg[0][v] <= s5_fit_reg[v];
                uv_box_reg[0][v]   <= s6_box_reg[v];
                for (int k = 1; k < DIV_LAT; k++)
                begin
                    fit_side_reg[k][v] <= fit_side_reg[k-1][v];
                    uv_box_reg[k][v]   <= uv_box_reg[k-1][v];
                end
                s6_box_reg[v] <= f_box[v];
                s7_out_reg[v] <= u_out[v];
            end
        end
        if (ob_load)
        begin
            ob_out_reg[0] <= s7_out_reg[0];
            ob_out_reg[1] <= s7_out_reg[1];
        end
    end

    // output buffer: left word, then right word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_vld_reg   <= 1'b0;
            ob_phase_reg <= 1'b0;
        end
        else if (ob_load)
        begin
            ob_vld_reg   <= 1'b1;
            ob_phase_reg <= 1'b0;
        end
        else if (ob_vld_reg && result_ready)
        begin
            ob_vld_reg   <= !ob_phase_reg;
            ob_phase_reg <= !ob_phase_reg;
        end
    end

    assign sel           = ob_out_reg[ob_phase_reg];
    assign result_valid  = ob_vld_reg;
    assign is_right_last = ob_phase_reg;
    assign rect_x        = sel.rect_x;
    assign rect_y        = sel.rect_y;
    assign rect_w        = sel.rect_w;
    assign rect_h        = sel.rect_h;
    assign u_lo          = sel.u_lo;
    assign u_hi          = sel.u_hi;
    assign v_lo          = sel.v_lo;
    assign v_hi          = sel.v_hi;
    assign comp_w        = sel.comp_w;
    assign comp_h        = sel.comp_h;
    assign layout_mode   = sel.mode;

    `DVAFL_ASSERT(a_phase_needs_word, !ob_phase_reg || ob_vld_reg, "right word without valid")
    `DVAFL_ASSERT_NEXT(a_left_then_right,
        result_valid && result_ready && !is_right_last,
        result_valid && is_right_last, "right word missing after left")
    `DVAFL_ASSERT_NEXT(a_tail_holds, vld_reg[PIPE_LEN-1] && !item_ready,
        vld_reg[PIPE_LEN-1], "stalled pipeline tail lost")
endmodule

[rtl/dvafl_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module dvafl_div
    import dvafl_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);
    logic [NUM_W-1:0] num_reg  [DIV_LAT];
    logic [DEN_W-1:0] den_reg  [DIV_LAT];
    logic [DEN_W-1:0] rem_reg  [DIV_LAT];
    logic [QUO_W-1:0] quo_reg  [DIV_LAT];
    logic [NUM_W-1:0] num_in   [DIV_LAT];
    logic [DEN_W-1:0] den_in   [DIV_LAT];
    logic [DEN_W-1:0] rem_in   [DIV_LAT];
    logic [QUO_W-1:0] quo_in   [DIV_LAT];
    logic [DEN_W:0]   trial    [DIV_LAT];
    logic [DEN_W-1:0] rem_next [DIV_LAT];
    logic [QUO_W-1:0] quo_next [DIV_LAT];

    assign num_in[0] = num;
    assign den_in[0] = den;
    assign rem_in[0] = DEN_W'(num[NUM_W-1:QUO_W]);
    assign quo_in[0] = '0;

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_link
        assign num_in[k] = num_reg[k-1];
        assign den_in[k] = den_reg[k-1];
        assign rem_in[k] = rem_reg[k-1];
        assign quo_in[k] = quo_reg[k-1];
    end

    always_comb
    begin
        for (int k = 0; k < DIV_LAT; k++)
        begin
            trial[k] = {rem_in[k], num_in[k][QUO_W-1-k]};
            if (trial[k] >= {1'b0, den_in[k]})
            begin
                rem_next[k] = DEN_W'(trial[k] - {1'b0, den_in[k]});
                quo_next[k] = quo_in[k] | (QUO_W'(1) << (QUO_W-1-k));
            end
            else
            begin
                rem_next[k] = trial[k][DEN_W-1:0];
                quo_next[k] = quo_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                num_reg[k] <= num_in[k];
                den_reg[k] <= den_in[k];
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_LAT-1];
endmodule

[tb/dual_view_aspect_fit_layout_core_test.sv]
// Testbench for the dual view aspect fit layout core: directed and random size pairs, scoreboard check.
`timescale 1ns / 1ps
module dual_view_aspect_fit_layout_core_test
    import dvafl_pkg::*;
();

    typedef struct packed {
        logic        last;
        logic [15:0] x, y, w, h;
        logic [16:0] ulo, uhi, vlo, vhi;
        logic [15:0] cw, ch;
        mode_t       mode;
    } view_t;

    class layout_board;
        view_t  pending[$];
        int     errors;
        logic [15:0] limit;

        function new();
            errors = 0;
            limit = TEXTURE_LIMIT_RST;
        endfunction

        function automatic void fit(input longint sw, sh, tx, ty, tw, th,
                                    output longint x, y, w, h);
            x = tx; y = ty; w = tw; h = th;
            if (sw == 0 || sh == 0 || tw == 0 || th == 0)
                return;
            if (sw * th > tw * sh)
            begin
                h = (tw * sh) / sw;
                y = ty + (th - h) / 2;
            end
            else
            begin
                w = (th * sw) / sh;
                x = tx + (tw - w) / 2;
            end
        endfunction

        function automatic logic [16:0] uv(longint p, longint total);
            if (total == 0)
                return 0;
            return 17'((p * 65536) / total);
        endfunction

        function automatic view_t pack_view(logic last, longint x, y, w, h, cw, ch,
                                            mode_t mode);
            view_t v;
            v.last = last;
            v.x = 16'(x); v.y = 16'(y); v.w = 16'(w); v.h = 16'(h);
            v.ulo = uv(x, cw); v.uhi = uv(x + w, cw);
            v.vlo = uv(y, ch); v.vhi = uv(y + h, ch);
            v.cw = 16'(cw); v.ch = 16'(ch);
            v.mode = mode;
            return v;
        endfunction

        function void note_sizes(logic [15:0] a, b, c, d);
            longint lw, lh, rw, rh, lim, hw, hh, vw, vh, cw, ch, m;
            longint slw, slh, srw, srh;
            longint lx, ly, lw2, lh2, rx, ry, rw2, rh2;
            mode_t mode;
            view_t v;
            lw = longint'(a); lh = longint'(b); rw = longint'(c); rh = longint'(d);
            lim = longint'(limit);
            if (lw == 0 || lh == 0 || rw == 0 || rh == 0)
            begin
                v = '0;
                v.mode = MODE_INVALID;
                pending.push_back(v);
                v.last = 1'b1;
                pending.push_back(v);
                return;
            end
            hw = lw + rw; hh = lh > rh ? lh : rh;
            vw = lw > rw ? lw : rw; vh = lh + rh;
            if (hw <= lim && hh <= lim)
            begin
                mode = MODE_SIDE; cw = hw; ch = hh;
                fit(lw, lh, 0, 0, lw, hh, lx, ly, lw2, lh2);
                fit(rw, rh, lw, 0, rw, hh, rx, ry, rw2, rh2);
            end
            else if (vw <= lim && vh <= lim)
            begin
                mode = MODE_STACK; cw = vw; ch = vh;
                fit(lw, lh, 0, 0, vw, lh, lx, ly, lw2, lh2);
                fit(rw, rh, 0, lh, vw, rh, rx, ry, rw2, rh2);
            end
            else
            begin
                m = hw > hh ? hw : hh;
                slw = lw * lim / m; slh = lh * lim / m;
                srw = rw * lim / m; srh = rh * lim / m;
                mode = MODE_SCALED;
                cw = slw + srw; ch = slh > srh ? slh : srh;
                fit(slw, slh, 0, 0, slw, ch, lx, ly, lw2, lh2);
                fit(srw, srh, slw, 0, srw, ch, rx, ry, rw2, rh2);
            end
            pending.push_back(pack_view(1'b0, lx, ly, lw2, lh2, cw, ch, mode));
            pending.push_back(pack_view(1'b1, rx, ry, rw2, rh2, cw, ch, mode));
        endfunction

        function void check_field(string name, logic [16:0] exp_val, logic [16:0] got_val);
            if (got_val !== exp_val)
            begin
                $error("%s exp %0d got %0d", name, exp_val, got_val);
                errors++;
            end
        endfunction

        function void check_view(view_t got);
            view_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = pending.pop_front();
            check_field("is_right_last", 17'(e.last), 17'(got.last));
            check_field("rect_x", 17'(e.x), 17'(got.x));
            check_field("rect_y", 17'(e.y), 17'(got.y));
            check_field("rect_w", 17'(e.w), 17'(got.w));
            check_field("rect_h", 17'(e.h), 17'(got.h));
            check_field("u_lo", e.ulo, got.ulo);
            check_field("u_hi", e.uhi, got.uhi);
            check_field("v_lo", e.vlo, got.vlo);
            check_field("v_hi", e.vhi, got.vhi);
            check_field("comp_w", 17'(e.cw), 17'(got.cw));
            check_field("comp_h", 17'(e.ch), 17'(got.ch));
            check_field("layout_mode", 17'(e.mode), 17'(got.mode));
        endfunction
    endclass

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata, prdata;
    logic item_valid, item_ready, result_valid, result_ready;
    logic [15:0] left_w, left_h, right_w, right_h;
    logic is_right_last;
    logic [15:0] rect_x, rect_y, rect_w, rect_h, comp_w, comp_h;
    logic [16:0] u_lo, u_hi, v_lo, v_hi;
    logic [1:0] layout_mode;
    logic feeding;

    layout_board board = new();

    dual_view_aspect_fit_layout_core dut (.*);

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    always @(posedge clk)
        if (rst_n && result_valid && result_ready)
            board.check_view({is_right_last, rect_x, rect_y, rect_w, rect_h,
                              u_lo, u_hi, v_lo, v_hi, comp_w, comp_h,
                              mode_t'(layout_mode)});

    always @(posedge clk)
        if (rst_n && item_valid && item_ready)
            board.note_sizes(left_w, left_h, right_w, right_h);

    initial
    begin
        int gap;
        result_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            result_ready = 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            gap = (feeding && $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                @(negedge clk);
                result_ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    task automatic write_limit(logic [15:0] value);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = PADDR_W'(REG_TEXTURE_LIMIT) << 2;
        pwdata = PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        board.limit = value;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic send_sizes(logic [15:0] a, b, c, d, bit wait_gap);
        if (wait_gap)
            repeat ($urandom_range(0, 9)) @(negedge clk);
        left_w = a; left_h = b; right_w = c; right_h = d;
        item_valid = 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_dim(logic [15:0] lim);
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(0, 3));
            2: return 16'hFFFF;
            3, 4: return 16'($urandom_range(1, lim));
            default: return 16'($urandom_range(1, (lim >> 1) + 1));
        endcase
    endfunction

    initial
    begin
        logic [15:0] limits[6];
        logic [15:0] lim;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        item_valid = 1'b0; left_w = '0; left_h = '0; right_w = '0; right_h = '0;
        feeding = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_sizes(16'd640, 16'd480, 16'd640, 16'd480, 0);
        send_sizes(16'd0, 16'd480, 16'd640, 16'd480, 1);
        send_sizes(16'd640, 16'd0, 16'd640, 16'd480, 1);
        send_sizes(16'd640, 16'd480, 16'd0, 16'd480, 1);
        send_sizes(16'd640, 16'd480, 16'd640, 16'd0, 1);
        send_sizes(16'd10000, 16'd100, 16'd10000, 16'd100, 1);
        send_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        send_sizes(16'd1, 16'd1, 16'd1, 16'd1, 1);
        send_sizes(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 1);
        send_sizes(16'd1920, 16'd1080, 16'd1080, 16'd1920, 0);
        send_sizes(16'd8192, 16'd8192, 16'd8192, 16'd8192, 0);
        send_sizes(16'd8192, 16'd8193, 16'd8192, 16'd8191, 0);
        send_sizes(16'd16384, 16'd1, 16'd16384, 16'd1, 1);
        drain();
        write_limit(16'd1);
        send_sizes(16'd1, 16'd1, 16'd1, 16'd1, 1);
        send_sizes(16'd3, 16'd1, 16'd1, 16'd3, 1);
        drain();
        write_limit(16'hFFFF);
        send_sizes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        send_sizes(16'h7FFF, 16'h1234, 16'h8000, 16'hABCD, 1);
        drain();

        limits[0] = 16'd16384; limits[1] = 16'd1; limits[2] = 16'hFFFF;
        limits[3] = 16'd2; limits[4] = 16'd1000; limits[5] = 16'($urandom_range(1, 65535));
        feeding = 1'b1;
        for (int p = 0; p < 6; p++)
        begin
            lim = limits[p];
            write_limit(lim);
            for (int i = 0; i < 250; i++)
                send_sizes(pick_dim(lim), pick_dim(lim), pick_dim(lim), pick_dim(lim),
                           $urandom_range(0, 2) != 0);
            drain();
        end
        feeding = 1'b0;

        if (board.errors == 0 && board.pending.size() == 0)
            $display("dual_view_aspect_fit_layout_core_test: done, clean");
        else
            $display("dual_view_aspect_fit_layout_core_test: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("dual_view_aspect_fit_layout_core_test: done, errors");
        $finish;
    end
endmodule
